FILE: hdl/tsch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsch_pkg
// Shared types and codes of the round robin / srtf / priority task scheduler.
// ----------------------------------------------------------------------------
package tsch_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_W          = 4;
  localparam int LEN_W         = 16;
  localparam int ELA_W         = 17;
  localparam int PRI_W         = 8;
  localparam int ALU_W         = 19;
  localparam logic [ELA_W-1:0] ELA_MAX = '1;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_READY = 2'd2;
  localparam logic [1:0] CMD_SLEEP = 2'd3;

  // policies
  localparam logic [1:0] RR    = 2'd0;
  localparam logic [1:0] SRTF  = 2'd1;
  localparam logic [1:0] PRIOP = 2'd2;

  // slot status
  localparam logic [2:0] ST_NEW        = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_WAITING    = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  // register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLICE  = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [ID_W-1:0]  task_id;
    logic [LEN_W-1:0] task_length;
    logic [PRI_W-1:0] task_priority;
  } in_t;

  typedef struct packed {
    logic            running_valid;
    logic [ID_W-1:0] running_task;
    logic            done_valid;
    logic [ID_W-1:0] done_task;
    logic            all_finished;
  } out_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] diff;
    logic                    lt;
  } alu_res_t;

endpackage
`default_nettype wire

FILE: hdl/tsch_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsch_alu
// Shared subtract and compare unit used by the tick, slice, key and compare steps.
// ----------------------------------------------------------------------------
module tsch_alu (
  input  wire logic signed [tsch_pkg::ALU_W-1:0] a,
  input  wire logic signed [tsch_pkg::ALU_W-1:0] b,
  output tsch_pkg::alu_res_t                     res
);

  always_comb begin
    res.diff = a - b;
    res.lt   = res.diff[tsch_pkg::ALU_W-1];
  end

endmodule
`default_nettype wire

FILE: hdl/task_scheduler_rr_srtf_priority.sv
`default_nettype none
// ----------------------------------------------------------------------------
// task_scheduler_rr_srtf_priority
// Task scheduler: load, ready, sleep and tick commands over a slot table
// with round robin, shortest remaining time and highest priority selection.
// ----------------------------------------------------------------------------
// a sleep on a queued task adds the queue search and shift; a tick may
//   run the selection scan (two passes of the shared alu per queue entry)
// throughput: one item at a time; in_ready is high only when idle
// reset: synchronous active low; slots new, queue empty, nothing running,
//   policy round robin, time slice 4
module task_scheduler_rr_srtf_priority #(
  parameter int MAX_TASKS = tsch_pkg::MAX_TASKS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tsch_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tsch_pkg::out_t       out_data,
  input  wire logic            cfg_psel,
  input  wire logic            cfg_penable,
  input  wire logic            cfg_pwrite,
  input  wire logic [2:0]      cfg_paddr,
  input  wire logic [31:0]     cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int NS = (MAX_TASKS < 16) ? MAX_TASKS : 16;
  localparam int IW = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW = $clog2(NS + 1);
  localparam int AW = tsch_pkg::ALU_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMD    = 4'd1;
  localparam logic [3:0] S_RMFIND = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_T0     = 4'd4;
  localparam logic [3:0] S_T1     = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_KEY    = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_GRAB   = 4'd9;
  localparam logic [3:0] S_RUN    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  // configuration
  logic [1:0] policy_r;
  logic [7:0] slice_len_r;

  // tables
  logic [tsch_pkg::LEN_W-1:0] len_tab  [NS];
  logic [tsch_pkg::ELA_W-1:0] ela_tab  [NS];
  logic [tsch_pkg::PRI_W-1:0] pri_tab  [NS];
  logic [2:0]                 st_tab_r [NS];
  logic [IW-1:0]              queue    [NS];

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    ret_r, ret_nxt;
  tsch_pkg::in_t item_r;
  logic [CW-1:0] qcnt_r, qcnt_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [7:0]    slice_r, slice_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] bpos_r, bpos_nxt;
  logic [AW-1:0] key_r, key_nxt, best_r, best_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] done_id_r, done_id_nxt;
  logic          out_valid_r;
  tsch_pkg::out_t out_r;

  // single read port and single write port on the slot tables and on the queue
  logic [CW-1:0] qa;
  logic [IW-1:0] qrd;
  logic [IW-1:0] ta;
  logic [2:0]    st_rd;
  logic [tsch_pkg::LEN_W-1:0] len_rd;
  logic [tsch_pkg::ELA_W-1:0] ela_rd;
  logic [tsch_pkg::PRI_W-1:0] pri_rd;

  // table write controls
  logic          st_we, load_we, ela_inc;
  logic [2:0]    st_wd;
  logic          q_we;
  logic [IW-1:0] q_wa, q_wd;

  logic signed [AW-1:0] alu_a, alu_b;
  tsch_pkg::alu_res_t   alu_res;
  logic id_ok;
  logic better;

  tsch_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign qa    = (state_r == S_SHIFT) ? idx_r + CW'(1) : idx_r;
  assign qrd   = queue[qa[IW-1:0]];
  assign id_ok = ({1'b0, item_r.task_id} < 5'(NS));

  always_comb begin
    unique case (state_r)
      S_T0, S_T1, S_RUN: ta = cur_r;
      S_KEY:             ta = qrd;
      default:           ta = item_r.task_id[IW-1:0];
    endcase
  end

  assign st_rd  = st_tab_r[ta];
  assign len_rd = len_tab[ta];
  assign ela_rd = ela_tab[ta];
  assign pri_rd = pri_tab[ta];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_T0: begin
        alu_a = AW'(ela_rd);
        alu_b = AW'(len_rd);
      end
      S_T1: begin
        alu_a = AW'(slice_r);
        alu_b = AW'(slice_len_r);
      end
      S_KEY: begin
        alu_a = AW'(len_rd);
        alu_b = AW'(ela_rd);
      end
      S_CMP: begin
        if (policy_r == tsch_pkg::SRTF) begin
          alu_a = key_r;
          alu_b = best_r;
        end else begin
          alu_a = best_r;
          alu_b = key_r;
        end
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign better = (idx_r == '0) || alu_res.lt;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    qcnt_nxt      = qcnt_r;
    wcnt_nxt      = wcnt_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    slice_nxt     = slice_r;
    idx_nxt       = idx_r;
    bpos_nxt      = bpos_r;
    key_nxt       = key_r;
    best_nxt      = best_r;
    done_nxt      = done_r;
    done_id_nxt   = done_id_r;
    st_we         = 1'b0;
    st_wd         = st_rd;
    load_we       = 1'b0;
    ela_inc       = 1'b0;
    q_we          = 1'b0;
    q_wa          = qcnt_r[IW-1:0];
    q_wd          = item_r.task_id[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          done_nxt    = 1'b0;
          done_id_nxt = '0;
          state_nxt   = (in_data.command == tsch_pkg::CMD_TICK) ? S_T0 : S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_DONE;
        if (id_ok) begin
          case (item_r.command)
            tsch_pkg::CMD_LOAD: begin
              if (st_rd == tsch_pkg::ST_NEW || st_rd == tsch_pkg::ST_TERMINATED) begin
                load_we = 1'b1;
                st_we   = 1'b1;
                st_wd   = tsch_pkg::ST_NEW;
              end
            end
            tsch_pkg::CMD_READY: begin
              if (st_rd == tsch_pkg::ST_NEW || st_rd == tsch_pkg::ST_WAITING) begin
                st_we = 1'b1;
                st_wd = tsch_pkg::ST_READY;
                if (st_rd == tsch_pkg::ST_WAITING) wcnt_nxt = wcnt_r - CW'(1);
                if (qcnt_r < CW'(NS)) begin
                  q_we     = 1'b1;
                  qcnt_nxt = qcnt_r + CW'(1);
                end
              end
            end
            tsch_pkg::CMD_SLEEP: begin
              if (st_rd == tsch_pkg::ST_READY || st_rd == tsch_pkg::ST_RUNNING ||
                  st_rd == tsch_pkg::ST_NEW) begin
                st_we    = 1'b1;
                st_wd    = tsch_pkg::ST_WAITING;
                wcnt_nxt = wcnt_r + CW'(1);
              end
              if (st_rd == tsch_pkg::ST_READY) begin
                idx_nxt   = '0;
                ret_nxt   = S_DONE;
                state_nxt = S_RMFIND;
              end else if (st_rd == tsch_pkg::ST_RUNNING) begin
                cur_valid_nxt = 1'b0;
                slice_nxt     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RMFIND: begin
        if (idx_r >= qcnt_r) begin
          state_nxt = ret_r;
        end else if (qrd == item_r.task_id[IW-1:0]) begin
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // close the gap one entry a cycle
        if (idx_r + CW'(1) < qcnt_r) begin
          q_we    = 1'b1;
          q_wa    = idx_r[IW-1:0];
          q_wd    = qrd;
          idx_nxt = idx_r + CW'(1);
        end else begin
          qcnt_nxt  = qcnt_r - CW'(1);
          state_nxt = ret_r;
        end
      end
      S_T0: begin
        if (!cur_valid_r) begin
          state_nxt = S_PICK;
        end else if (!alu_res.lt) begin
          st_we         = 1'b1;
          st_wd         = tsch_pkg::ST_TERMINATED;
          cur_valid_nxt = 1'b0;
          done_nxt      = 1'b1;
          done_id_nxt   = cur_r;
          state_nxt     = S_PICK;
        end else begin
          state_nxt = S_T1;
        end
      end
      S_T1: begin
        if (!alu_res.lt) begin
          // slice used up, back to the tail
          st_we         = 1'b1;
          st_wd         = tsch_pkg::ST_READY;
          cur_valid_nxt = 1'b0;
          q_wd          = cur_r;
          if (qcnt_r < CW'(NS)) begin
            q_we     = 1'b1;
            qcnt_nxt = qcnt_r + CW'(1);
          end
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_PICK: begin
        idx_nxt  = '0;
        bpos_nxt = '0;
        if (cur_valid_r) begin
          state_nxt = S_RUN;
        end else if (qcnt_r == '0) begin
          state_nxt = S_DONE;
        end else if (policy_r == tsch_pkg::SRTF || policy_r == tsch_pkg::PRIOP) begin
          state_nxt = S_KEY;
        end else begin
          state_nxt = S_GRAB;
        end
      end
      S_KEY: begin
        key_nxt   = (policy_r == tsch_pkg::SRTF) ? alu_res.diff : AW'(pri_rd);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (better) begin
          best_nxt = key_r;
          bpos_nxt = idx_r;
        end
        if (idx_r + CW'(1) < qcnt_r) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_KEY;
        end else begin
          idx_nxt   = better ? idx_r : bpos_r;
          state_nxt = S_GRAB;
        end
      end
      S_GRAB: begin
        cur_nxt       = qrd;
        cur_valid_nxt = 1'b1;
        slice_nxt     = '0;
        ret_nxt       = S_RUN;
        state_nxt     = S_SHIFT;
      end
      S_RUN: begin
        st_we   = 1'b1;
        st_wd   = tsch_pkg::ST_RUNNING;
        ela_inc = (ela_rd != tsch_pkg::ELA_MAX);
        if (slice_r != 8'hFF) slice_nxt = slice_r + 8'd1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_DONE;
      qcnt_r      <= '0;
      wcnt_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      slice_r     <= '0;
      done_r      <= 1'b0;
      done_id_r   <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= tsch_pkg::RR;
      slice_len_r <= 8'd4;
      for (int i = 0; i < NS; i++) st_tab_r[i] <= tsch_pkg::ST_NEW;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      qcnt_r      <= qcnt_nxt;
      wcnt_r      <= wcnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      slice_r     <= slice_nxt;
      done_r      <= done_nxt;
      done_id_r   <= done_id_nxt;
      if (st_we) st_tab_r[ta] <= st_wd;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == tsch_pkg::REG_POLICY) policy_r <= cfg_pwdata[1:0];
        else                                      slice_len_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    bpos_r <= bpos_nxt;
    key_r  <= key_nxt;
    best_r <= best_nxt;
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    if (load_we) begin
      len_tab[ta] <= item_r.task_length;
      pri_tab[ta] <= item_r.task_priority;
      ela_tab[ta] <= '0;
    end else if (ela_inc) begin
      ela_tab[ta] <= ela_rd + tsch_pkg::ELA_W'(1);
    end
    if (q_we) queue[q_wa] <= q_wd;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.running_valid <= cur_valid_r;
      out_r.running_task  <= cur_valid_r ? 4'(cur_r) : 4'd0;
      out_r.done_valid    <= done_r;
      out_r.done_task     <= done_r ? 4'(done_id_r) : 4'd0;
      out_r.all_finished  <= !cur_valid_r && (qcnt_r == '0) && (wcnt_r == '0);
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tsch_pkg::REG_POLICY) ? {30'd0, policy_r}
                                                             : {24'd0, slice_len_r};

`ifndef ASSERT_OFF
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= CW'(NS)) else $error("ready queue count beyond slot count");

  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= CW'(NS)) else $error("sleeping count beyond slot count");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");

  a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_valid && out_r.running_valid)
      |-> (out_r.done_task != out_r.running_task))
    else $error("terminated task still reported running");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_task_scheduler_rr_srtf_priority.sv
// ----------------------------------------------------------------------------
// tb_task_scheduler_rr_srtf_priority
// Drives load, ready, sleep and tick commands into the scheduler under every
// policy and several slice settings. Each result beat is checked against a
// cycle-free scheduler model kept in the bench.
// ----------------------------------------------------------------------------
module tb_task_scheduler_rr_srtf_priority;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = 16;
  localparam int CYCLE_CAP = 1500000;
  localparam int DRAIN     = 3 * NSLOT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tsch_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tsch_pkg::out_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task_scheduler_rr_srtf_priority DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // scheduler model state
  logic [1:0]                 sm_policy;
  logic [7:0]                 sm_slice;
  logic [tsch_pkg::LEN_W-1:0] sm_len [NSLOT];
  logic [tsch_pkg::ELA_W-1:0] sm_ela [NSLOT];
  logic [tsch_pkg::PRI_W-1:0] sm_pri [NSLOT];
  logic [2:0]                 sm_stat[NSLOT];
  logic [tsch_pkg::ID_W-1:0]  sm_queue[$];
  logic                       sm_run;
  logic [tsch_pkg::ID_W-1:0]  sm_cur;
  logic [7:0]                 sm_used;
  bit                         sm_loaded[NSLOT];

  tsch_pkg::out_t sched_expected[$];
  int   errors = 0, n_items = 0, n_results = 0, n_done = 0, cycles = 0;
  bit   finished = 0;

  function automatic int pick_slot_pos();
    int best, i;
    int br, r;
    best = 0;
    if (sm_policy == tsch_pkg::SRTF) begin
      br = int'(sm_len[sm_queue[0]]) - int'(sm_ela[sm_queue[0]]);
      for (i = 1; i < sm_queue.size(); i++) begin
        r = int'(sm_len[sm_queue[i]]) - int'(sm_ela[sm_queue[i]]);
        if (r < br) begin
          br = r;
          best = i;
        end
      end
    end else if (sm_policy == tsch_pkg::PRIOP) begin
      for (i = 1; i < sm_queue.size(); i++)
        if (sm_pri[sm_queue[i]] > sm_pri[sm_queue[best]]) best = i;
    end
    return best;
  endfunction

  function automatic tsch_pkg::out_t schedule_step(tsch_pkg::in_t it);
    tsch_pkg::out_t o;
    int pos, i;
    bit asleep;
    logic [2:0] st;
    o = '0;
    if (it.command == tsch_pkg::CMD_TICK) begin
      if (sm_run) begin
        if (sm_ela[sm_cur] >= {1'b0, sm_len[sm_cur]}) begin
          sm_stat[sm_cur] = tsch_pkg::ST_TERMINATED;
          sm_run = 0;
          o.done_valid = 1'b1;
          o.done_task = sm_cur;
        end else if (sm_used >= sm_slice) begin
          sm_stat[sm_cur] = tsch_pkg::ST_READY;
          sm_queue.insert(sm_queue.size(), sm_cur);
          sm_run = 0;
        end
      end
      if (!sm_run && sm_queue.size() != 0) begin
        pos = pick_slot_pos();
        sm_cur = sm_queue[pos];
        sm_queue.delete(pos);
        sm_run = 1;
        sm_used = '0;
      end
      if (sm_run) begin
        sm_stat[sm_cur] = tsch_pkg::ST_RUNNING;
        if (sm_ela[sm_cur] != tsch_pkg::ELA_MAX) sm_ela[sm_cur]++;
        if (sm_used != 8'hFF) sm_used++;
      end
    end else begin
      st = sm_stat[it.task_id];
      if (it.command == tsch_pkg::CMD_LOAD) begin
        if (st == tsch_pkg::ST_NEW || st == tsch_pkg::ST_TERMINATED) begin
          sm_len[it.task_id] = it.task_length;
          sm_pri[it.task_id] = it.task_priority;
          sm_ela[it.task_id] = '0;
          sm_stat[it.task_id] = tsch_pkg::ST_NEW;
          sm_loaded[it.task_id] = 1;
        end
      end else if (it.command == tsch_pkg::CMD_READY) begin
        if (st == tsch_pkg::ST_NEW || st == tsch_pkg::ST_WAITING) begin
          sm_stat[it.task_id] = tsch_pkg::ST_READY;
          sm_queue.insert(sm_queue.size(), it.task_id);
        end
      end else begin
        if (st == tsch_pkg::ST_READY) begin
          for (i = 0; i < sm_queue.size(); i++)
            if (sm_queue[i] == it.task_id) begin
              sm_queue.delete(i);
              break;
            end
          sm_stat[it.task_id] = tsch_pkg::ST_WAITING;
        end else if (st == tsch_pkg::ST_RUNNING) begin
          sm_run = 0;
          sm_used = '0;
          sm_stat[it.task_id] = tsch_pkg::ST_WAITING;
        end else if (st == tsch_pkg::ST_NEW) begin
          sm_stat[it.task_id] = tsch_pkg::ST_WAITING;
        end
      end
    end
    asleep = 0;
    for (i = 0; i < NSLOT; i++) if (sm_stat[i] == tsch_pkg::ST_WAITING) asleep = 1;
    o.running_valid = sm_run;
    o.running_task = sm_run ? sm_cur : '0;
    o.all_finished = !sm_run && sm_queue.size() == 0 && !asleep;
    return o;
  endfunction

  // a ready on a slot never loaded would read undefined entries
  function automatic tsch_pkg::in_t legalize(tsch_pkg::in_t it);
    if (it.command == tsch_pkg::CMD_READY && !sm_loaded[it.task_id] &&
        sm_stat[it.task_id] inside {tsch_pkg::ST_NEW, tsch_pkg::ST_WAITING})
      it.command = tsch_pkg::CMD_LOAD;
    return it;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  task automatic send_cmd(tsch_pkg::in_t it, bit has_want, tsch_pkg::out_t want);
    tsch_pkg::out_t pred;
    int gap;
    it = legalize(it);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pred = schedule_step(it);
    if (has_want && pred != want) begin
      $error("directed row exp %p model %p", want, pred);
      errors++;
    end
    sched_expected.insert(sched_expected.size(), has_want ? want : pred);
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 3'd4 * tsch_pkg::REG_POLICY) sm_policy = val[1:0];
    else sm_slice = val[7:0];
  endtask

  function automatic tsch_pkg::in_t mk(logic [1:0] c, logic [3:0] id, logic [15:0] l,
                                       logic [7:0] p);
    tsch_pkg::in_t it;
    it.command = c;
    it.task_id = id;
    it.task_length = l;
    it.task_priority = p;
    return it;
  endfunction

  function automatic tsch_pkg::out_t res(bit rv, logic [3:0] rt, bit dv, logic [3:0] dt,
                                         bit af);
    tsch_pkg::out_t o;
    o.running_valid = rv;
    o.running_task = rt;
    o.done_valid = dv;
    o.done_task = dt;
    o.all_finished = af;
    return o;
  endfunction

  typedef struct {
    tsch_pkg::in_t  cmd;
    bit             has_want;
    tsch_pkg::out_t want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(tsch_pkg::in_t c, bit h, tsch_pkg::out_t w);
    row_t rw;
    rw.cmd = c;
    rw.has_want = h;
    rw.want = w;
    rows.insert(rows.size(), rw);
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (cycles % 64 < 16) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    tsch_pkg::out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (sched_expected.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        w = sched_expected.pop_front();
        n_results++;
        if (out_data.done_valid) n_done++;
        if (out_data.running_valid !== w.running_valid) begin
          $error("running_valid exp %0d got %0d", w.running_valid, out_data.running_valid);
          errors++;
        end
        if (out_data.running_task !== w.running_task) begin
          $error("running_task exp %0d got %0d", w.running_task, out_data.running_task);
          errors++;
        end
        if (out_data.done_valid !== w.done_valid) begin
          $error("done_valid exp %0d got %0d", w.done_valid, out_data.done_valid);
          errors++;
        end
        if (out_data.done_task !== w.done_task) begin
          $error("done_task exp %0d got %0d", w.done_task, out_data.done_task);
          errors++;
        end
        if (out_data.all_finished !== w.all_finished) begin
          $error("all_finished exp %0d got %0d", w.all_finished, out_data.all_finished);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP && !finished) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    tsch_pkg::in_t it;
    int   i, ph, k, r, id;
    logic [7:0] slices[6];
    slices = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd4, 8'd7};
    sm_policy = tsch_pkg::RR;
    sm_slice = 8'd4;
    sm_run = 0;
    sm_cur = '0;
    sm_used = '0;
    for (i = 0; i < NSLOT; i++) begin
      sm_len[i] = '0;
      sm_ela[i] = '0;
      sm_pri[i] = '0;
      sm_stat[i] = tsch_pkg::ST_NEW;
      sm_loaded[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(mk(tsch_pkg::CMD_TICK, 4'd0, 16'd0, 8'd0), 1'b1,
            res(1'b0, 4'd0, 1'b0, 4'd0, 1'b1));
    add_row(mk(tsch_pkg::CMD_LOAD, 4'd0, 16'd0, 8'd0), 1'b1,
            res(1'b0, 4'd0, 1'b0, 4'd0, 1'b1));
    add_row(mk(tsch_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 8'hFF), 1'b1,
            res(1'b0, 4'd0, 1'b0, 4'd0, 1'b1));
    add_row(mk(tsch_pkg::CMD_LOAD, 4'd5, 16'd3, 8'h80), 1'b1,
            res(1'b0, 4'd0, 1'b0, 4'd0, 1'b1));
    add_row(mk(tsch_pkg::CMD_READY, 4'd0, 16'd0, 8'd0), 1'b1,
            res(1'b0, 4'd0, 1'b0, 4'd0, 1'b0));
    add_row(mk(tsch_pkg::CMD_TICK, 4'd0, 16'd0, 8'd0), 1'b1,
            res(1'b1, 4'd0, 1'b0, 4'd0, 1'b0));
    // zero-length task ends on the next tick
    add_row(mk(tsch_pkg::CMD_TICK, 4'd0, 16'd0, 8'd0), 1'b1,
            res(1'b0, 4'd0, 1'b1, 4'd0, 1'b1));
    add_row(mk(tsch_pkg::CMD_READY, 4'd0, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_LOAD, 4'd0, 16'd2, 8'd1), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_READY, 4'd15, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_READY, 4'd5, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_READY, 4'd0, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_LOAD, 4'd15, 16'd1, 8'd1), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_TICK, 4'd0, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_SLEEP, 4'd15, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_SLEEP, 4'd5, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_SLEEP, 4'd9, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_READY, 4'd9, 16'd0, 8'd0), 1'b0, '0);
    add_row(mk(tsch_pkg::CMD_READY, 4'd15, 16'd0, 8'd0), 1'b0, '0);
    for (i = 0; i < 6; i++)
      add_row(mk(tsch_pkg::CMD_TICK, 4'd0, 16'd0, 8'd0), 1'b0, '0);
    foreach (rows[j]) send_cmd(rows[j].cmd, rows[j].has_want, rows[j].want);
    wait_idle();

    // random phases over policies and slice settings, extremes included
    for (ph = 0; ph < 8; ph++) begin
      write_reg(3'd4 * tsch_pkg::REG_POLICY, 32'(ph % 4));
      write_reg(3'd4 * tsch_pkg::REG_SLICE, {24'd0, slices[ph % 6]});
      for (k = 0; k < 128; k++) begin
        r = $urandom_range(0, 99);
        id = $urandom_range(0, 15);
        // mostly short tasks so terminations are frequent
        if (r < 45)
          it = mk(tsch_pkg::CMD_TICK, 4'($urandom), 16'($urandom), 8'($urandom));
        else if (r < 65)
          it = mk(tsch_pkg::CMD_LOAD, 4'(id),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                  8'($urandom));
        else if (r < 88)
          it = mk(tsch_pkg::CMD_READY, 4'(id), 16'($urandom), 8'($urandom));
        else
          it = mk(tsch_pkg::CMD_SLEEP, 4'(id), 16'($urandom), 8'($urandom));
        send_cmd(it, 1'b0, '0);
        if (k == 64 && ph == 3) wait_idle();
      end
      wait_idle();
    end

    finished = 1;
    $display("covered %0d commands, %0d result beats, %0d terminations",
             n_items, n_results, n_done);
    $display("policies 0..3 with time slices 0, 1, 2, 4, 7 and 255");
    if (errors == 0 && sched_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/tsch_pkg.sv
hdl/tsch_alu.sv
hdl/task_scheduler_rr_srtf_priority.sv
verif/tb_task_scheduler_rr_srtf_priority.sv
